// ===== src/clp_pkg.sv =====
// ----------------------------------------------------------------------------
// clp_pkg
// Types, character codes and helpers shared by the CSS length token parser.
// ----------------------------------------------------------------------------
package clp_pkg;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_INT  = 3'd1,
    PH_FRAC = 3'd2,
    PH_TAIL = 3'd3,
    PH_REM  = 3'd4,
    PH_AUTO = 3'd5,
    PH_BAD  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    UNIT_NONE = 3'd0,
    UNIT_PX   = 3'd1,
    UNIT_VW   = 3'd2,
    UNIT_VH   = 3'd3,
    UNIT_EM   = 3'd4,
    UNIT_PCT  = 3'd5
  } unit_e;

  localparam int unsigned IntW   = 22;
  localparam int unsigned FracW  = 10;
  localparam int unsigned ValueW = 31;

  localparam logic [IntW-1:0]   IntCap   = 22'd2147484;
  localparam logic [31:0]       Scale    = 32'd1000;
  localparam logic [ValueW-1:0] ValueMax = 31'h7FFF_FFFF;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChO     = 8'h6F;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChX     = 8'h78;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic              valid_res;
    logic              is_auto_value;
    logic [IntW-1:0]   int_part;
    logic [FracW-1:0]  frac_part;
    logic [1:0]        frac_digits;
    unit_e             unit;
  } token_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [7:0] auto_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = ChA;
      2'd1:    r = ChU;
      2'd2:    r = ChT;
      default: r = ChO;
    endcase
    return r;
  endfunction

endpackage

// ===== src/clp_if.sv =====
// ----------------------------------------------------------------------------
// clp_in_if / clp_out_if
// Valid/ready channels for token characters and parse results.
// ----------------------------------------------------------------------------
interface clp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface clp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic        is_auto_value;
  logic [30:0] value_thousandths;
  logic [2:0]  unit_code;

  modport source (output valid, output valid_res, output is_auto_value,
                  output value_thousandths, output unit_code, input ready);
  modport sink   (input valid, input valid_res, input is_auto_value,
                  input value_thousandths, input unit_code, output ready);
endinterface

// ===== src/clp_input_reg.sv =====
// ----------------------------------------------------------------------------
// clp_input_reg
// Input register for token characters.
// ----------------------------------------------------------------------------
module clp_input_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  clp_in_if.sink         in_i,
  output logic           valid_o,
  output clp_pkg::item_t item_o,
  input  logic           ready_i
);

  logic           valid_q;
  logic           valid_d;
  clp_pkg::item_t item_q;
  logic           take;

  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.char_code <= in_i.char_code;
      item_q.is_final  <= in_i.is_final;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/clp_scan.sv =====
// ----------------------------------------------------------------------------
// clp_scan
// Per-character token scanner; captures the token summary at the last byte.
// ----------------------------------------------------------------------------
module clp_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  clp_pkg::item_t  item_i,
  output logic            ready_o,
  output logic            tok_valid_o,
  output clp_pkg::token_t tok_o,
  input  logic            tok_ready_i
);

  localparam int unsigned IntW  = clp_pkg::IntW;
  localparam int unsigned FracW = clp_pkg::FracW;

  clp_pkg::phase_e       phase_q, phase_d;
  logic [IntW-1:0]       int_q, int_d;
  logic [FracW-1:0]      frac_q, frac_d;
  logic [1:0]            fdig_q, fdig_d;
  logic                  saw_q, saw_d;
  logic [2:0]            acnt_q, acnt_d;
  logic [1:0][7:0]       uc_q, uc_d;
  logic [1:0]            rlen_q, rlen_d;
  logic [1:0]            pend_q, pend_d;

  logic                  tok_valid_q, tok_valid_d;
  clp_pkg::token_t       tok_q, tok_d;

  logic                  take;
  logic [7:0]            c;
  logic [7:0]            lc;
  logic                  ws;
  logic                  dig;
  logic                  dot;
  logic [3:0]            digit;
  logic [IntW+3:0]       int_next;
  logic [FracW+3:0]      frac_next;
  logic                  do_rem;
  logic [2:0]            rem_end;
  logic [2:0]            rem_len;
  logic                  numeric;
  logic                  auto_ok;
  logic [7:0]            ua;
  logic [7:0]            ub;

  assign c     = item_i.char_code;
  assign lc    = clp_pkg::to_lower(c);
  assign ws    = clp_pkg::is_space(c);
  assign dig   = (c >= clp_pkg::ChZero) && (c <= clp_pkg::ChNine);
  assign dot   = (c == clp_pkg::ChDot);
  assign digit = 4'(c - clp_pkg::ChZero);

  assign int_next  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + (IntW+4)'(digit);
  assign frac_next = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1) + (FracW+4)'(digit);
  assign rem_end   = {1'b0, rlen_q} + {1'b0, pend_q};
  assign rem_len   = rem_end + 3'd1;

  always_comb begin
    phase_d = phase_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fdig_d  = fdig_q;
    saw_d   = saw_q;
    acnt_d  = acnt_q;
    uc_d    = uc_q;
    rlen_d  = rlen_q;
    pend_d  = pend_q;
    do_rem  = 1'b0;

    unique case (phase_q)
      clp_pkg::PH_LEAD: begin
        if (!ws) begin
          if (dig) begin
            int_d   = (int_next > (IntW+4)'(clp_pkg::IntCap)) ? clp_pkg::IntCap
                                                             : int_next[IntW-1:0];
            saw_d   = 1'b1;
            phase_d = clp_pkg::PH_INT;
          end else if (dot) begin
            phase_d = clp_pkg::PH_FRAC;
          end else if (lc == clp_pkg::auto_char(2'd0)) begin
            acnt_d  = 3'd1;
            phase_d = clp_pkg::PH_AUTO;
          end else begin
            phase_d = clp_pkg::PH_BAD;
          end
        end
      end
      clp_pkg::PH_INT: begin
        if (dig) begin
          int_d = (int_next > (IntW+4)'(clp_pkg::IntCap)) ? clp_pkg::IntCap
                                                         : int_next[IntW-1:0];
          saw_d = 1'b1;
        end else if (dot) begin
          phase_d = clp_pkg::PH_FRAC;
        end else begin
          do_rem = 1'b1;
        end
      end
      clp_pkg::PH_FRAC: begin
        if (dig) begin
          if (fdig_q != 2'd3) begin
            frac_d = frac_next[FracW-1:0];
            fdig_d = fdig_q + 2'd1;
            saw_d  = 1'b1;
          end else begin
            phase_d = clp_pkg::PH_TAIL;
          end
        end else if (dot) begin
          phase_d = clp_pkg::PH_TAIL;
        end else begin
          do_rem = 1'b1;
        end
      end
      clp_pkg::PH_TAIL: begin
        if (!dig && !dot) begin
          do_rem = 1'b1;
        end
      end
      clp_pkg::PH_REM: begin
        do_rem = 1'b1;
      end
      clp_pkg::PH_AUTO: begin
        if (ws) begin
          if (pend_q != 2'd3) begin
            pend_d = pend_q + 2'd1;
          end
        end else if (pend_q != 2'd0 || acnt_q[2] ||
                     lc != clp_pkg::auto_char(acnt_q[1:0])) begin
          phase_d = clp_pkg::PH_BAD;
        end else begin
          acnt_d = acnt_q + 3'd1;
        end
      end
      default: begin
      end
    endcase

    if (do_rem) begin
      phase_d = clp_pkg::PH_REM;
      if (ws) begin
        if (pend_q != 2'd3) begin
          pend_d = pend_q + 2'd1;
        end
      end else begin
        for (int i = 0; i < 2; i++) begin
          if (3'(i) >= {1'b0, rlen_q} && 3'(i) <= rem_end) begin
            uc_d[i] = (3'(i) == rem_end) ? c : clp_pkg::ChSpace;
          end
        end
        rlen_d = (rem_len > 3'd3) ? 2'd3 : rem_len[1:0];
        pend_d = 2'd0;
      end
    end
  end

  // Summarize the token from the post-step state
  assign ua      = clp_pkg::to_lower(uc_d[0]);
  assign ub      = clp_pkg::to_lower(uc_d[1]);
  assign auto_ok = (phase_d == clp_pkg::PH_AUTO) && (acnt_d == 3'd4);
  assign numeric = saw_d && (phase_d == clp_pkg::PH_INT || phase_d == clp_pkg::PH_FRAC ||
                             phase_d == clp_pkg::PH_TAIL || phase_d == clp_pkg::PH_REM);

  always_comb begin
    tok_d.valid_res     = auto_ok || numeric;
    tok_d.is_auto_value = auto_ok;
    tok_d.int_part      = numeric ? int_d : '0;
    tok_d.frac_part     = numeric ? frac_d : '0;
    tok_d.frac_digits   = numeric ? fdig_d : 2'd0;
    tok_d.unit          = clp_pkg::UNIT_NONE;
    if (numeric && phase_d == clp_pkg::PH_REM) begin
      if (rlen_d == 2'd1 && uc_d[0] == clp_pkg::ChPct) begin
        tok_d.unit = clp_pkg::UNIT_PCT;
      end else if (rlen_d == 2'd2) begin
        if (ua == clp_pkg::ChP && ub == clp_pkg::ChX) begin
          tok_d.unit = clp_pkg::UNIT_PX;
        end else if (ua == clp_pkg::ChV && ub == clp_pkg::ChW) begin
          tok_d.unit = clp_pkg::UNIT_VW;
        end else if (ua == clp_pkg::ChV && ub == clp_pkg::ChH) begin
          tok_d.unit = clp_pkg::UNIT_VH;
        end else if (ua == clp_pkg::ChE && ub == clp_pkg::ChM) begin
          tok_d.unit = clp_pkg::UNIT_EM;
        end
      end
    end
  end

  assign ready_o = !item_i.is_final || !tok_valid_q || tok_ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    tok_valid_d = tok_valid_q;
    if (take && item_i.is_final) begin
      tok_valid_d = 1'b1;
    end else if (tok_ready_i) begin
      tok_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= clp_pkg::PH_LEAD;
      int_q       <= '0;
      frac_q      <= '0;
      fdig_q      <= 2'd0;
      saw_q       <= 1'b0;
      acnt_q      <= 3'd0;
      uc_q        <= '0;
      rlen_q      <= 2'd0;
      pend_q      <= 2'd0;
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
      if (take) begin
        if (item_i.is_final) begin
          phase_q <= clp_pkg::PH_LEAD;
          int_q   <= '0;
          frac_q  <= '0;
          fdig_q  <= 2'd0;
          saw_q   <= 1'b0;
          acnt_q  <= 3'd0;
          uc_q    <= '0;
          rlen_q  <= 2'd0;
          pend_q  <= 2'd0;
        end else begin
          phase_q <= phase_d;
          int_q   <= int_d;
          frac_q  <= frac_d;
          fdig_q  <= fdig_d;
          saw_q   <= saw_d;
          acnt_q  <= acnt_d;
          uc_q    <= uc_d;
          rlen_q  <= rlen_d;
          pend_q  <= pend_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.is_final) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== src/clp_finish.sv =====
// ----------------------------------------------------------------------------
// clp_finish
// Scales the token number to thousandths, saturates, and registers the result.
// ----------------------------------------------------------------------------
module clp_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  clp_pkg::token_t tok_i,
  output logic            tok_ready_o,
  clp_out_if.source       out_o
);

  localparam int unsigned FracW  = clp_pkg::FracW;
  localparam int unsigned ValueW = clp_pkg::ValueW;

  logic              valid_q, valid_d;
  logic              res_valid_q;
  logic              res_auto_q;
  logic [ValueW-1:0] res_value_q;
  logic [2:0]        res_unit_q;
  logic [FracW-1:0]  frac_sc;
  logic [31:0]       sum;
  logic [ValueW-1:0] value;
  logic              load;

  always_comb begin
    case (tok_i.frac_digits)
      2'd0:    frac_sc = '0;
      2'd1:    frac_sc = FracW'(tok_i.frac_part * 7'd100);
      2'd2:    frac_sc = FracW'(tok_i.frac_part * 4'd10);
      default: frac_sc = tok_i.frac_part;
    endcase
  end

  assign sum   = 32'(tok_i.int_part) * clp_pkg::Scale + 32'(frac_sc);
  assign value = sum[31] ? clp_pkg::ValueMax : sum[ValueW-1:0];

  assign tok_ready_o = !valid_q || out_o.ready;
  assign load        = tok_valid_i && tok_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_valid_q <= tok_i.valid_res;
      res_auto_q  <= tok_i.is_auto_value;
      res_value_q <= value;
      res_unit_q  <= tok_i.unit;
    end
  end

  assign out_o.valid             = valid_q;
  assign out_o.valid_res         = res_valid_q;
  assign out_o.is_auto_value     = res_auto_q;
  assign out_o.value_thousandths = res_value_q;
  assign out_o.unit_code         = res_unit_q;

endmodule

// ===== src/css_length_token_parser_unit.sv =====
// ----------------------------------------------------------------------------
// css_length_token_parser_unit
// Parses a CSS length token, one character per transaction, into a value in
// thousandths, a unit code and an auto flag.
// ----------------------------------------------------------------------------
// The block takes one character every clock cycle while the result channel
// does not stall, with no gaps between tokens, including back to back tokens.
// The character sits in the input register from the accepting edge. The
// character scanner folds each character into the token state and captures
// the token summary in its token register when it takes the last character.
// The finishing stage multiplies by 1000 with saturation and loads the result
// register. The scanner's one-character-per-cycle state update sets the
// sustained rate.
module css_length_token_parser_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  clp_in_if.sink    in_i,
  clp_out_if.source out_o
);

  logic            s1_valid;
  clp_pkg::item_t  s1_item;
  logic            s1_ready;
  logic            tok_valid;
  clp_pkg::token_t tok;
  logic            tok_ready;

  clp_input_reg u_input_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (s1_valid),
    .item_o  (s1_item),
    .ready_i (s1_ready)
  );

  clp_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .ready_o     (s1_ready),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_ready_i (tok_ready)
  );

  clp_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .out_o       (out_o)
  );

endmodule

// ===== test/css_length_token_checker.sv =====
// ----------------------------------------------------------------------------
// css_length_token_checker
// Watches the character and result channels of the CSS length token parser,
// predicts each token result from the accepted characters, and compares every
// result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module css_length_token_checker
  import clp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_char_i,
  input  logic              in_final_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              out_valid_res_i,
  input  logic              out_auto_i,
  input  logic [ValueW-1:0] out_value_i,
  input  logic [2:0]        out_unit_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  typedef struct packed {
    logic              valid_res;
    logic              is_auto_value;
    logic [ValueW-1:0] value;
    unit_e             unit;
  } length_t;

  localparam logic [7:0] AutoWord [4] = '{ChA, ChU, ChT, ChO};

  length_t expected_lengths[$];

  phase_e      ph;
  logic [31:0] int_acc;
  logic [9:0]  frac_acc;
  logic [1:0]  frac_n;
  logic        digit_seen;
  logic        seen_point;
  logic [2:0]  auto_n;
  logic [7:0]  rem_c0;
  logic [7:0]  rem_c1;
  logic [1:0]  rem_len;
  logic [1:0]  pend_sp;

  assign pending_o = expected_lengths.size();

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  task automatic clear_token();
    ph         = PH_LEAD;
    int_acc    = '0;
    frac_acc   = '0;
    frac_n     = '0;
    digit_seen = 1'b0;
    seen_point = 1'b0;
    auto_n     = '0;
    rem_c0     = '0;
    rem_c1     = '0;
    rem_len    = '0;
    pend_sp    = '0;
  endtask

  task automatic add_int_digit(input logic [7:0] c);
    int_acc = int_acc * 32'd10 + 32'(c - ChZero);
    if (int_acc > 32'(IntCap)) begin
      int_acc = 32'(IntCap);
    end
    digit_seen = 1'b1;
  endtask

  task automatic push_rem(input logic [7:0] c);
    if (rem_len == 2'd0) begin
      rem_c0 = c;
    end else if (rem_len == 2'd1) begin
      rem_c1 = c;
    end
    if (rem_len != 2'd3) begin
      rem_len = rem_len + 2'd1;
    end
  endtask

  task automatic rem_char(input logic [7:0] c, input logic ws);
    if (ws) begin
      if (pend_sp != 2'd3) begin
        pend_sp = pend_sp + 2'd1;
      end
    end else begin
      while (pend_sp != 2'd0) begin
        push_rem(ChSpace);
        pend_sp = pend_sp - 2'd1;
      end
      push_rem(c);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic        ws;
    logic        dig;
    logic [7:0]  lc;
    logic [7:0]  u0;
    logic [7:0]  u1;
    logic [63:0] frac_scaled;
    logic [63:0] total;
    length_t     res;
    ws  = is_blank(c);
    dig = (c >= ChZero) && (c <= ChNine);
    lc  = lower(c);
    case (ph)
      PH_LEAD: begin
        if (!ws) begin
          if (dig) begin
            add_int_digit(c);
            ph = PH_INT;
          end else if (c == ChDot) begin
            seen_point = 1'b1;
            ph = PH_FRAC;
          end else if (lc == ChA) begin
            auto_n = 3'd1;
            ph = PH_AUTO;
          end else begin
            ph = PH_BAD;
          end
        end
      end
      PH_INT: begin
        if (dig) begin
          add_int_digit(c);
        end else if (c == ChDot) begin
          seen_point = 1'b1;
          ph = PH_FRAC;
        end else begin
          ph = PH_REM;
          rem_char(c, ws);
        end
      end
      PH_FRAC: begin
        if (dig) begin
          if (frac_n != 2'd3) begin
            frac_acc   = frac_acc * 10'd10 + 10'(c - ChZero);
            frac_n     = frac_n + 2'd1;
            digit_seen = 1'b1;
          end else begin
            ph = PH_TAIL;
          end
        end else if (c == ChDot) begin
          ph = PH_TAIL;
        end else begin
          ph = PH_REM;
          rem_char(c, ws);
        end
      end
      PH_TAIL: begin
        if (!dig && c != ChDot) begin
          ph = PH_REM;
          rem_char(c, ws);
        end
      end
      PH_REM: rem_char(c, ws);
      PH_AUTO: begin
        if (ws) begin
          if (pend_sp != 2'd3) begin
            pend_sp = pend_sp + 2'd1;
          end
        end else if (pend_sp != 2'd0 || auto_n >= 3'd4 || lc != AutoWord[auto_n[1:0]]) begin
          ph = PH_BAD;
        end else begin
          auto_n = auto_n + 3'd1;
        end
      end
      default: ;
    endcase

    if (fin) begin
      res.valid_res     = 1'b0;
      res.is_auto_value = 1'b0;
      res.value         = '0;
      res.unit          = UNIT_NONE;
      if (ph == PH_AUTO) begin
        if (auto_n == 3'd4) begin
          res.valid_res     = 1'b1;
          res.is_auto_value = 1'b1;
        end
      end else if ((ph == PH_INT || ph == PH_FRAC || ph == PH_TAIL || ph == PH_REM) &&
                   digit_seen) begin
        frac_scaled = 64'(frac_acc);
        for (int n = frac_n; n < 3; n++) begin
          frac_scaled = frac_scaled * 64'd10;
        end
        total = 64'(int_acc) * 64'(Scale) + frac_scaled;
        res.valid_res = 1'b1;
        res.value     = (total > 64'(ValueMax)) ? ValueMax : total[ValueW-1:0];
        if (ph == PH_REM) begin
          u0 = lower(rem_c0);
          u1 = lower(rem_c1);
          if (rem_len == 2'd1 && rem_c0 == ChPct) begin
            res.unit = UNIT_PCT;
          end else if (rem_len == 2'd2) begin
            if (u0 == ChP && u1 == ChX) begin
              res.unit = UNIT_PX;
            end else if (u0 == ChV && u1 == ChW) begin
              res.unit = UNIT_VW;
            end else if (u0 == ChV && u1 == ChH) begin
              res.unit = UNIT_VH;
            end else if (u0 == ChE && u1 == ChM) begin
              res.unit = UNIT_EM;
            end
          end
        end
      end
      expected_lengths.push_back(res);
      clear_token();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    length_t got;
    length_t want;
    if (!rst_ni) begin
      clear_token();
      expected_lengths.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.valid_res     = out_valid_res_i;
        got.is_auto_value = out_auto_i;
        got.value         = out_value_i;
        got.unit          = unit_e'(out_unit_i);
        if (expected_lengths.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none expected: valid=%0d auto=%0d value=%0d unit=%0d",
                   $time, got.valid_res, got.is_auto_value, got.value, got.unit);
        end else begin
          want = expected_lengths.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display("%0t: mismatch expected valid=%0d auto=%0d value=%0d unit=%0d",
                     $time, want.valid_res, want.is_auto_value, want.value, want.unit);
            $display("%0t:          actual   valid=%0d auto=%0d value=%0d unit=%0d",
                     $time, got.valid_res, got.is_auto_value, got.value, got.unit);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_char(in_char_i, in_final_i);
      end
    end
  end

endmodule

// ===== test/css_length_token_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// css_length_token_parser_unit_tb
// Feeds the CSS length token parser with directed and random tokens under
// varying source and sink stalls; a checker beside the block predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module css_length_token_parser_unit_tb;
  import clp_pkg::*;

  typedef logic [7:0] text_t[$];

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned sent_chars;
  text_t       tok;

  clp_in_if  in_ch ();
  clp_out_if out_ch ();

  css_length_token_parser_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  css_length_token_checker length_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_char_i       (in_ch.char_code),
    .in_final_i      (in_ch.is_final),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_valid_res_i (out_ch.valid_res),
    .out_auto_i      (out_ch.is_auto_value),
    .out_value_i     (out_ch.value_thousandths),
    .out_unit_i      (out_ch.unit_code),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? ChSpace : 8'h09 + 8'(r);
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= ChA && c <= 8'h7A && $urandom_range(1) == 1) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic text_t make_token();
    text_t       t;
    text_t       w;
    string       units [8];
    string       u;
    int unsigned n;
    int unsigned mode;
    units = '{"px", "vw", "vh", "em", "%", "", "q", "p x"};
    repeat ($urandom_range(2)) t.push_back(blank_char());
    mode = $urandom_range(99);
    if (mode < 15) begin
      w = {any_case(ChA), any_case(ChU), any_case(ChT), any_case(ChO)};
      case ($urandom_range(7))
        0: w.insert($urandom_range(1, 3), blank_char());
        1: w.push_back(8'($urandom_range(255)));
        2: void'(w.pop_back());
        default: ;
      endcase
      foreach (w[i]) t.push_back(w[i]);
    end else if (mode < 85) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      repeat (n) t.push_back(ChZero + 8'($urandom_range(9)));
      if ($urandom_range(1) == 1) begin
        t.push_back(ChDot);
        repeat ($urandom_range(5)) t.push_back(ChZero + 8'($urandom_range(9)));
        if ($urandom_range(5) == 0) begin
          t.push_back(ChDot);
          repeat ($urandom_range(2)) t.push_back(ChZero + 8'($urandom_range(9)));
        end
      end
      n = $urandom_range(7);
      if (n == 6) begin
        repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(255)));
      end else begin
        u = units[n];
        for (int i = 0; i < u.len(); i++) t.push_back(any_case(u[i]));
      end
    end else begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
    end
    repeat ($urandom_range(2)) t.push_back(blank_char());
    if (t.size() == 0) begin
      t.push_back(blank_char());
    end
    return t;
  endfunction

  task automatic put_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_final  <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_token(input text_t t);
    foreach (t[i]) put_char(t[i], i == t.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_token(t);
  endtask

  // hold the source idle until every predicted result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.is_final   = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(" ");
    send_text("AuTo");
    send_text(".");
    put_char(8'hFF, 1'b1);
    send_text("1.5vH");
    put_char(ChZero, 1'b0);
    put_char(8'h00, 1'b1);
    send_text("9999999%");
    send_text("1.2.3");
    drain_results();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 7 : (p == 1) ? 61 : 0;
      recv_idle_pct = (p == 0) ? 61 : (p == 1) ? 7 : 0;
      sent_chars = 0;
      while (sent_chars < 317) begin
        tok = make_token();
        send_token(tok);
        sent_chars += tok.size();
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
